// ===== rtl/core/swlap_pkg.sv =====
// Shared types, digit limits and the seven-segment decode for the stopwatch.
package swlap_pkg;

    localparam int unsigned NUM_DIGITS = 6;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned IN_W       = 8;
    localparam int unsigned RES_W      = 56;

    // Key bit positions inside the keys field
    localparam int unsigned KEY_START = 0;
    localparam int unsigned KEY_STOP  = 1;
    localparam int unsigned KEY_LAP   = 2;
    localparam int unsigned KEY_CLEAR = 3;

    // Highest value of each digit, hundredths ones first: HH, SS, MM
    localparam logic [DIGIT_W-1:0] DIGIT_LAST [0:NUM_DIGITS-1] =
        '{4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5};

    typedef struct packed {
        logic step;
        logic lap;
        logic clear;
        logic show_lap;
    } cell_ctrl_t;

    typedef logic [RES_W-1:0] result_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/swlap_digit_cell.sv =====
// One BCD digit of live and lap time, with carry to the next digit and segment decode.
module swlap_digit_cell
    import swlap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [DIGIT_W-1:0] wrap_at,
    input  logic               carry_in,
    output logic               carry_out,
    output logic [SEG_W-1:0]   seg
);

    logic [DIGIT_W-1:0] live_reg, live_next;
    logic [DIGIT_W-1:0] lap_reg, lap_next;
    logic [DIGIT_W-1:0] live_inc;
    logic [DIGIT_W-1:0] disp;
    logic               at_wrap;

    always_comb
    begin
        at_wrap   = (live_reg == wrap_at);
        carry_out = carry_in && at_wrap;
        live_inc  = at_wrap ? '0 : live_reg + DIGIT_W'(1);

        // lap takes the digit from before this beat's tick
        priority if (ctrl.clear)
        begin
            live_next = '0;
            lap_next  = '0;
        end
        else
        begin
            live_next = carry_in ? live_inc : live_reg;
            lap_next  = ctrl.lap ? live_reg : lap_reg;
        end

        disp = ctrl.show_lap ? lap_next : live_next;
        seg  = seg_of(disp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            lap_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            live_reg <= live_next;
            lap_reg  <= lap_next;
        end
    end

endmodule

// ===== rtl/core/swlap_out_skid.sv =====
// Output register with a skid stage so the input side keeps moving while a result waits.
module swlap_out_skid
    import swlap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    push;
    logic    take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        push            = in_valid && !skid_valid_reg;
        take            = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid beat first; no push is possible here
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/core/stopwatch_lap_seven_segment_top.sv =====
// Top level of the MM:SS:HH stopwatch with lap memory and seven-segment output.
//
//  channel | dir | fields (tdata, lowest bit up)
//  s_      | in  | keys[3:0], tick[4], show_lap[5], zero pad [7:6]
//  m_      | out | seg_sec_hun[31:0], seg_min[47:32], is_running[48], zero pad [55:49]
//
// One beat per clock while s_tready is high: every accepted input beat updates the digit
// chain in the same cycle and yields one result beat, held in the output or skid register.
// The tick carry ripples through six digit cells within that cycle.
// Reset clears live time, lap time and the running flag.
// A stalled m_ side fills the skid stage; s_tready drops only while it is full.
module stopwatch_lap_seven_segment_top
    import swlap_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,   // keys[3:0], tick[4], show_lap[5]
    output logic            m_tvalid,
    input  logic            m_tready,
    output result_t         m_tdata    // seg_sec_hun[31:0], seg_min[47:32], is_running[48]
);

    logic               counting_reg, counting_next;
    logic               step;
    logic [3:0]         keys;
    logic               tick;
    cell_ctrl_t         ctrl;
    logic [NUM_DIGITS:0] carry;
    logic [SEG_W-1:0]   seg [0:NUM_DIGITS-1];
    result_t            result;

    assign keys = s_tdata[3:0];
    assign tick = s_tdata[4];
    assign step = s_tvalid && s_tready;

    always_comb
    begin
        priority if (keys[KEY_CLEAR] || keys[KEY_STOP])
            counting_next = 1'b0;
        else if (keys[KEY_START])
            counting_next = 1'b1;
        else
            counting_next = counting_reg;

        ctrl.step     = step;
        ctrl.lap      = keys[KEY_LAP];
        ctrl.clear    = keys[KEY_CLEAR];
        ctrl.show_lap = s_tdata[5];
    end

    // a start press drops this beat's tick
    assign carry[0] = step && counting_next && tick && !keys[KEY_START];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counting_reg <= 1'b0;
        else if (step)
            counting_reg <= counting_next;
    end

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_digit
        swlap_digit_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wrap_at   (DIGIT_LAST[i]),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .seg       (seg[i])
        );
    end

    assign result = {7'd0, counting_next,
                     seg[5], seg[4], seg[3], seg[2], seg[1], seg[0]};

    swlap_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== rtl/core/swlap_checker.sv =====
// Port-level checks for the stopwatch top level, bound into it.
module swlap_checker
    import swlap_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic [IN_W-1:0] s_tdata,
    input logic            m_tvalid,
    input logic            m_tready,
    input result_t         m_tdata
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // input side stalls only while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // clear shows 00:00:00 stopped on the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[KEY_CLEAR] && !m_tvalid |=>
            m_tvalid && !m_tdata[48] && (m_tdata[47:0] == 48'h3F3F_3F3F_3F3F))
        else $error("clear did not zero the display");

    // start alone leaves the watch running
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[KEY_START] && !s_tdata[KEY_STOP]
            && !s_tdata[KEY_CLEAR] && !m_tvalid
            |=> m_tvalid && m_tdata[48])
        else $error("start did not set running");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[55:49] == 7'd0))
        else $error("result pad bits not zero");

endmodule

bind stopwatch_lap_seven_segment_top swlap_checker u_swlap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
